### rtl/core/pct2d_pkg.sv
// Shared types and constants for the 2D pair collision test pipeline.
package pct2d_pkg;

	// Default coordinate field width (signed Q11.4 positions, unsigned Q12.4 sizes).
	localparam int COORD_BITS_DEF = 16;

	// Width of the pass-through pair tag.
	localparam int TAG_BITS = 16;

	// Which test applies to the pair.
	typedef enum logic [1:0] {
		MODE_BB = 2'd0, // box against box
		MODE_CC = 2'd1, // circle against circle
		MODE_BC = 2'd2  // box against circle
	} mode_t;

	// Stage load enables handed to the distance lanes.
	typedef struct packed {
		logic adv_s4;
		logic adv_s5;
	} pct2d_en_t;

endpackage

### rtl/core/pct2d_dist.sv
// One distance lane: strict test dx^2 + dy^2 < r^2 over two pipeline stages.
module pct2d_dist
	import pct2d_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  pct2d_en_t                 en,
	input  logic signed [COORD_BITS+2:0] dx,
	input  logic signed [COORD_BITS+2:0] dy,
	input  logic        [COORD_BITS:0]   r,
	output logic                      lt
);

	localparam int DW = COORD_BITS + 3;   // signed delta
	localparam int MW = COORD_BITS + 2;   // magnitude of a delta
	localparam int RW = COORD_BITS + 1;   // radius bound
	localparam int SW = 2 * MW + 1;       // sum of two squares

	logic signed [DW-1:0] neg_dx;
	logic signed [DW-1:0] neg_dy;
	logic [MW-1:0]   ax_s4;
	logic [MW-1:0]   ay_s4;
	logic [RW-1:0]   r_s4;
	logic [2*MW-1:0] sqx_s5;
	logic [2*MW-1:0] sqy_s5;
	logic [2*RW-1:0] rsq_s5;
	logic [SW-1:0]   sum;

	assign neg_dx = -dx;
	assign neg_dy = -dy;

	// Stage 4: magnitudes (deltas never reach the most negative code)
	always_ff @(posedge clk) begin
		if (en.adv_s4) begin
			ax_s4 <= dx[DW-1] ? neg_dx[MW-1:0] : dx[MW-1:0];
			ay_s4 <= dy[DW-1] ? neg_dy[MW-1:0] : dy[MW-1:0];
			r_s4  <= r;
		end
	end

	// Stage 5: squares
	always_ff @(posedge clk) begin
		if (en.adv_s5) begin
			sqx_s5 <= ax_s4 * ax_s4;
			sqy_s5 <= ay_s4 * ay_s4;
			rsq_s5 <= r_s4 * r_s4;
		end
	end

	// Sum and strict compare, registered by the caller
	assign sum = SW'(sqx_s5) + SW'(sqy_s5);
	assign lt  = sum < SW'(rsq_s5);

endmodule

### rtl/core/pair_collision_test_2d.sv
// Top level: six-stage pipelined narrow-phase collision test for one 2D collider pair.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    shape_a, pos_x_a, pos_y_a, size_w_a, size_h_a,
//                                    shape_b, pos_x_b, pos_y_b, size_w_b, size_h_b, pair_tag
//   output    out_valid / out_ready  collided, tag_out
//
// One pair enters per cycle while the output is not stalled; each result passes the stages
// select, edges, clamp, magnitude, square and compare, in that order.
// Each stage holds its item while the stage after it is full and stalled, so a held
// output still lets earlier stages fill; in_ready is high whenever out_ready is high.
// arst_n clears the stage valid bits only; the block keeps no other state.
module pair_collision_test_2d
	import pct2d_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         shape_a,
	input  logic signed [COORD_BITS-1:0] pos_x_a,
	input  logic signed [COORD_BITS-1:0] pos_y_a,
	input  logic        [COORD_BITS-1:0] size_w_a,
	input  logic        [COORD_BITS-1:0] size_h_a,
	input  logic                         shape_b,
	input  logic signed [COORD_BITS-1:0] pos_x_b,
	input  logic signed [COORD_BITS-1:0] pos_y_b,
	input  logic        [COORD_BITS-1:0] size_w_b,
	input  logic        [COORD_BITS-1:0] size_h_b,
	input  logic        [TAG_BITS-1:0]   pair_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         collided,
	output logic        [TAG_BITS-1:0]   tag_out
);

	localparam int N  = COORD_BITS;
	localparam int PW = N + 1;   // doubled position
	localparam int EW = N + 2;   // box edge, centre difference
	localparam int DW = N + 3;   // edge-to-centre delta
	localparam int NL = 4;       // distance lanes

	// Stage valid bits and advance controls
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	pct2d_en_t en;

	// Stage 1: operands with box side and circle side sorted out
	mode_t                 mode_s1;
	logic signed [PW-1:0]  bx_s1, by_s1, cx_s1, cy_s1;
	logic        [N-1:0]   bw_s1, bh_s1, cw_s1, ch_s1;
	logic [TAG_BITS-1:0]   tag_s1;

	// Stage 2: box edges and centre differences
	mode_t                 mode_s2;
	logic signed [EW-1:0]  xlo_s2, xhi_s2, ylo_s2, yhi_s2;
	logic signed [EW-1:0]  dxc_s2, dyc_s2;
	logic signed [PW-1:0]  cx_s2, cy_s2;
	logic        [N-1:0]   bw_s2, bh_s2, cw_s2, ch_s2;
	logic [TAG_BITS-1:0]   tag_s2;

	// Stage 3: lane deltas and the box pair result
	mode_t                 mode_s3;
	logic signed [DW-1:0]  dx_s3 [NL];
	logic signed [DW-1:0]  dy_s3 [NL];
	logic        [N:0]     rw_s3, rh_s3;
	logic                  bb_s3;
	logic [TAG_BITS-1:0]   tag_s3;

	// Stages 4 and 5 ride alongside the lanes
	mode_t                 mode_s4, mode_s5;
	logic                  bb_s4, bb_s5;
	logic [TAG_BITS-1:0]   tag_s4, tag_s5;
	logic                  lt_s5 [NL];

	// Stage 6: output register
	logic                  collided_s6;
	logic [TAG_BITS-1:0]   tag_s6;

	// Combinational helpers
	logic                  swap;
	mode_t                 mode_in;
	logic signed [EW-1:0]  cx_e, cy_e, sx, sy;
	logic signed [EW-1:0]  neg_dxc, neg_dyc;
	logic        [N:0]     adx, ady, sumw, sumh;
	logic                  hit;

	// Ready ripples back: a stage loads when it is empty or its holder moves on
	always_comb begin
		rdy6 = !valid_s6 || out_ready;
		rdy5 = !valid_s5 || rdy6;
		rdy4 = !valid_s4 || rdy5;
		rdy3 = !valid_s3 || rdy4;
		rdy2 = !valid_s2 || rdy3;
		rdy1 = !valid_s1 || rdy2;
		en.adv_s4 = rdy4 && valid_s3;
		en.adv_s5 = rdy5 && valid_s4;
	end

	assign in_ready  = rdy1;
	assign out_valid = valid_s6;
	assign collided  = collided_s6;
	assign tag_out   = tag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: pick the test and put the box (or first circle) on the box side
	always_comb begin
		swap = shape_a && !shape_b;
		if (!shape_a && !shape_b) begin
			mode_in = MODE_BB;
		end else if (shape_a && shape_b) begin
			mode_in = MODE_CC;
		end else begin
			mode_in = MODE_BC;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1 <= mode_in;
			tag_s1  <= pair_tag;
			if (swap) begin
				bx_s1 <= {pos_x_b, 1'b0};
				by_s1 <= {pos_y_b, 1'b0};
				bw_s1 <= size_w_b;
				bh_s1 <= size_h_b;
				cx_s1 <= {pos_x_a, 1'b0};
				cy_s1 <= {pos_y_a, 1'b0};
				cw_s1 <= size_w_a;
				ch_s1 <= size_h_a;
			end else begin
				bx_s1 <= {pos_x_a, 1'b0};
				by_s1 <= {pos_y_a, 1'b0};
				bw_s1 <= size_w_a;
				bh_s1 <= size_h_a;
				cx_s1 <= {pos_x_b, 1'b0};
				cy_s1 <= {pos_y_b, 1'b0};
				cw_s1 <= size_w_b;
				ch_s1 <= size_h_b;
			end
		end
	end

	// Stage 2: box edges in doubled units, centre differences
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			mode_s2 <= mode_s1;
			tag_s2  <= tag_s1;
			xlo_s2  <= EW'(bx_s1) - EW'($signed({1'b0, bw_s1}));
			xhi_s2  <= EW'(bx_s1) + EW'($signed({1'b0, bw_s1}));
			ylo_s2  <= EW'(by_s1) - EW'($signed({1'b0, bh_s1}));
			yhi_s2  <= EW'(by_s1) + EW'($signed({1'b0, bh_s1}));
			dxc_s2  <= EW'(bx_s1) - EW'(cx_s1);
			dyc_s2  <= EW'(by_s1) - EW'(cy_s1);
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			bw_s2   <= bw_s1;
			bh_s2   <= bh_s1;
			cw_s2   <= cw_s1;
			ch_s2   <= ch_s1;
		end
	end

	// Stage 3: clamp the circle centre onto the box, box pair overlap
	always_comb begin
		cx_e = EW'(cx_s2);
		cy_e = EW'(cy_s2);
		if (ylo_s2 > cy_e) begin
			sy = ylo_s2;
		end else if (yhi_s2 < cy_e) begin
			sy = yhi_s2;
		end else begin
			sy = cy_e;
		end
		if (xlo_s2 > cx_e) begin
			sx = xlo_s2;
		end else if (xhi_s2 < cx_e) begin
			sx = xhi_s2;
		end else begin
			sx = cx_e;
		end
		neg_dxc = -dxc_s2;
		neg_dyc = -dyc_s2;
		adx  = dxc_s2[EW-1] ? neg_dxc[N:0] : dxc_s2[N:0];
		ady  = dyc_s2[EW-1] ? neg_dyc[N:0] : dyc_s2[N:0];
		sumw = {1'b0, bw_s2} + {1'b0, cw_s2};
		sumh = {1'b0, bh_s2} + {1'b0, ch_s2};
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			mode_s3 <= mode_s2;
			tag_s3  <= tag_s2;
			bb_s3   <= (adx < sumw) && (ady < sumh);
			// Right edge against half the width; lane 0 takes the left edge
			dx_s3[1] <= DW'(xhi_s2) - DW'(cx_s2);
			dy_s3[1] <= DW'(sy) - DW'(cy_s2);
			// Top and bottom edges against half the height
			dx_s3[2] <= DW'(sx) - DW'(cx_s2);
			dy_s3[2] <= DW'(yhi_s2) - DW'(cy_s2);
			dx_s3[3] <= DW'(sx) - DW'(cx_s2);
			dy_s3[3] <= DW'(ylo_s2) - DW'(cy_s2);
			rh_s3    <= {1'b0, ch_s2};
			// Lane 0 carries the circle pair test in that mode
			if (mode_s2 == MODE_CC) begin
				dx_s3[0] <= DW'(dxc_s2);
				dy_s3[0] <= DW'(dyc_s2);
				rw_s3    <= sumw;
			end else begin
				dx_s3[0] <= DW'(xlo_s2) - DW'(cx_s2);
				dy_s3[0] <= DW'(sy) - DW'(cy_s2);
				rw_s3    <= {1'b0, cw_s2};
			end
		end
	end

	// Stages 4 and 5: distance lanes
	for (genvar g = 0; g < NL; g++) begin : g_lane
		pct2d_dist #(
			.COORD_BITS(COORD_BITS)
		) u_dist (
			.clk (clk),
			.en  (en),
			.dx  (dx_s3[g]),
			.dy  (dy_s3[g]),
			.r   ((g < 2) ? rw_s3 : rh_s3),
			.lt  (lt_s5[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en.adv_s4) begin
			mode_s4 <= mode_s3;
			bb_s4   <= bb_s3;
			tag_s4  <= tag_s3;
		end
		if (en.adv_s5) begin
			mode_s5 <= mode_s4;
			bb_s5   <= bb_s4;
			tag_s5  <= tag_s4;
		end
	end

	// Stage 6: pick the verdict for the pair's mode
	always_comb begin
		case (mode_s5)
			MODE_BB: hit = bb_s5;
			MODE_CC: hit = lt_s5[0];
			MODE_BC: hit = lt_s5[0] || lt_s5[1] || lt_s5[2] || lt_s5[3];
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy6 && valid_s5) begin
			collided_s6 <= hit;
			tag_s6      <= tag_s5;
		end
	end

endmodule

### rtl/core/pct2d_chk.sv
// Port-level checker for the pair collision test, bound to the top level.
module pct2d_chk
	import pct2d_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [TAG_BITS-1:0] pair_tag,
	input logic                out_valid,
	input logic                out_ready,
	input logic                collided,
	input logic [TAG_BITS-1:0] tag_out
);

	// A stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pair_tag))
		else $error("input item changed while stalled");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_out) && $stable(collided))
		else $error("result changed while stalled");

	// With the output free the pipeline always takes a new item
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with a free output");

	// An accepted item shows up as a result when the output never stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
		##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing six cycles after accept");

endmodule

bind pair_collision_test_2d pct2d_chk u_pct2d_chk (.*);
